// ===== design/swa_pkg.sv =====
// Shared constants, types and the sigmoid sample table of the swish unit.
`default_nettype none

package swa_pkg;

    // Fixed sample format and configuration of the lookup.
    localparam int X_W                   = 16;
    localparam int FRAC_BITS             = 12;
    localparam int SIGMOID_TABLE_ENTRIES = 256;

    // Sigmoid samples are unsigned Q16; one extra bit holds 1.0.
    localparam int SAMP_W  = 17;
    localparam int DELTA_W = SAMP_W + 1;
    localparam int IDX_W   = $clog2(SIGMOID_TABLE_ENTRIES);

    // One table segment spans 2^FRAC_W positions of the scaled input.
    localparam int FRAC_W  = FRAC_BITS + 4;
    localparam int OFF_W   = ((FRAC_BITS + 5 > X_W + 1) ? FRAC_BITS + 5 : X_W + 1) + 1;
    localparam int P_W     = FRAC_W + IDX_W;
    localparam int IPROD_W = DELTA_W + FRAC_W + 1;
    localparam int NUM_W   = IPROD_W + 1;

    // Datapath widths of the swish and gradient arithmetic.
    localparam int FPROD_W = X_W + SAMP_W + 1;
    localparam int FY_W    = FPROD_W - 16;
    localparam int Q_W     = 2 * SAMP_W - 1;
    localparam int XQ_W    = X_W + Q_W + 1;
    localparam int SSH_W   = SAMP_W + FRAC_BITS + 17;
    localparam int BIG_W   = ((SSH_W > XQ_W) ? SSH_W : XQ_W) + 1;
    localparam int DQ_W    = BIG_W - (FRAC_BITS + 16);
    localparam int GP_W    = X_W + DQ_W;
    localparam int BY_W    = GP_W - 16;

    // Register stages from input beat to output register.
    localparam int PIPE_DEPTH = 8;

    typedef enum logic {
        OP_FWD = 1'b0,
        OP_BWD = 1'b1
    } t_op;

    typedef logic [SAMP_W-1:0] t_samp;

    typedef struct packed {
        t_samp                     base;
        logic signed [DELTA_W-1:0] delta;
    } t_rom_entry;

    typedef t_rom_entry [SIGMOID_TABLE_ENTRIES-1:0] t_rom;

    // Beat between the sigmoid lookup and the arithmetic back end.
    typedef struct packed {
        t_op                   op;
        logic signed [X_W-1:0] x_sample;
        logic signed [X_W-1:0] grad_in;
        t_samp                 sig;
    } t_mid_beat;

    // Rounding constants (half up).
    localparam logic [NUM_W-1:0]   INTERP_RND = NUM_W'(1) << (FRAC_W - 1);
    localparam logic [FPROD_W-1:0] FWD_RND    = FPROD_W'(1) << 15;
    localparam logic [BIG_W-1:0]   DQ_RND     = BIG_W'(1) << (FRAC_BITS + 15);
    localparam logic [GP_W-1:0]    GRAD_RND   = GP_W'(1) << 15;
    localparam logic [SAMP_W-1:0]  Q16_ONE    = SAMP_W'(1) << 16;

    // Input offset that maps -8.0 to zero, and the top of the table span.
    localparam logic signed [OFF_W-1:0] OFF_BIAS = OFF_W'(8) << FRAC_BITS;
    localparam logic signed [OFF_W-1:0] OFF_LIM  = OFF_W'(16) << FRAC_BITS;

    localparam logic signed [BY_W-1:0] Y_MAX = BY_W'(32767);
    localparam logic signed [BY_W-1:0] Y_MIN = -BY_W'(32768);

    localparam longint Q30_ONE = longint'(1) <<< 30;

    // Q30 product, rounded half up.
    function automatic longint q30_mul(longint a, longint b);
        return (a * b + (longint'(1) <<< 29)) >>> 30;
    endfunction

    // Truncating quotient of a non-negative numerator by a positive divisor,
    // worked out one bit at a time while the table is built.
    function automatic longint udiv(longint num, longint den);
        longint q;
        longint r;
        q = 0;
        r = 0;
        for (int b = 62; b >= 0; b--) begin
            r = (r <<< 1) | ((num >>> b) & longint'(1));
            q = q <<< 1;
            if (r >= den) begin
                r = r - den;
                q = q | longint'(1);
            end
        end
        return q;
    endfunction

    // Sigmoid at sample point i of the span [-8, 8], unsigned Q16.
    // exp(-|x|) comes from a short series at |x|/256, squared eight times.
    function automatic longint tab_sample(int i);
        longint t;
        longint m;
        longint y;
        longint y2;
        longint y3;
        longint y4;
        longint e;
        longint den;
        longint r;
        t  = 16 * longint'(i) - 8 * longint'(SIGMOID_TABLE_ENTRIES);
        m  = (t < 0) ? -t : t;
        y  = udiv((m <<< 22) + longint'(SIGMOID_TABLE_ENTRIES / 2),
                  longint'(SIGMOID_TABLE_ENTRIES));
        y2 = q30_mul(y, y);
        y3 = q30_mul(y2, y);
        y4 = q30_mul(y3, y);
        e  = Q30_ONE - y + (y2 >>> 1) - udiv(y3, longint'(6)) + udiv(y4, longint'(24));
        for (int k = 0; k < 8; k++) begin
            e = q30_mul(e, e);
        end
        den = Q30_ONE + e;
        if (t >= 0) begin
            r = udiv((longint'(1) <<< 46) + (den >>> 1), den);
        end else begin
            r = udiv((e <<< 16) + (den >>> 1), den);
        end
        return r;
    endfunction

    // Each entry holds a sample and the step to the next one.
    function automatic t_rom build_rom();
        t_rom   rom;
        longint a;
        longint b;
        for (int i = 0; i < SIGMOID_TABLE_ENTRIES; i++) begin
            a = tab_sample(i);
            b = tab_sample(i + 1);
            rom[i].base  = t_samp'(a);
            rom[i].delta = DELTA_W'(b - a);
        end
        return rom;
    endfunction

    localparam t_rom  SIG_ROM = build_rom();
    localparam t_samp TAB_TOP = t_samp'(tab_sample(SIGMOID_TABLE_ENTRIES));

endpackage

`default_nettype wire

// ===== design/swa_if.sv =====
// Valid/ready channel interfaces of the swish unit.
`default_nettype none

interface swa_in_if;
    import swa_pkg::*;

    logic                  valid;
    logic                  ready;
    t_op                   op;
    logic signed [X_W-1:0] x_sample;
    logic signed [X_W-1:0] grad_in;

    modport source (output valid, output op, output x_sample, output grad_in, input ready);
    modport sink   (input valid, input op, input x_sample, input grad_in, output ready);
endinterface

interface swa_mid_if;
    import swa_pkg::*;

    logic      valid;
    logic      ready;
    t_mid_beat beat;

    modport source (output valid, output beat, input ready);
    modport sink   (input valid, input beat, output ready);
endinterface

interface swa_out_if;
    import swa_pkg::*;

    logic                  valid;
    logic                  ready;
    logic signed [X_W-1:0] y_value;
    logic                  saturated;

    modport source (output valid, output y_value, output saturated, input ready);
    modport sink   (input valid, input y_value, input saturated, output ready);
endinterface

`default_nettype wire

// ===== design/swish_activation_fwd_bwd.sv =====
// Swish (SiLU) forward and backward unit, top level.
// Takes one sample per cycle while the output side is not stalled and returns one result
// per sample through the stage registers below. op selects x*sigmoid(x) or the input
// gradient grad*(s + x*s*(1-s)); all values are signed Q4.12 and results are rounded half
// up, clipped to 16 bits and flagged when clipped. The sigmoid is interpolated from a
// constant table of samples over [-8, 8]; inputs outside that span use the end samples.
// Three stages form the sigmoid (segment index, table read with slope product,
// interpolation) and five the arithmetic (two multiplier stages, derivative rounding,
// gradient product, saturation into the output register). Each stage holds a valid bit
// and fills when empty, so input ready stays high while a result waits as long as a
// stage is free; the latency is set by the multiplier chain of the backward path.
`default_nettype none

module swish_activation_fwd_bwd (
    input  wire         i_clk,
    input  wire         i_rst_n,
    swa_in_if.sink      i_in,
    swa_out_if.source   o_out
);
    import swa_pkg::*;

    swa_mid_if u_mid ();

    // Sigmoid lookup and interpolation.
    swa_sigmoid u_sigmoid (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_mid   (u_mid.source)
    );

    // Swish and gradient arithmetic.
    swa_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mid   (u_mid.sink),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

// ===== design/swa_sigmoid.sv =====
// Three-stage sigmoid lookup: segment index, table read with slope product, interpolation.
`default_nettype none

module swa_sigmoid (
    input  wire           i_clk,
    input  wire           i_rst_n,
    swa_in_if.sink        i_in,
    swa_mid_if.source     o_mid
);
    import swa_pkg::*;

    logic [2:0] r_vld;
    logic [2:0] en;

    // Stage 1 registers.
    t_op                   r_op1;
    logic signed [X_W-1:0] r_x1;
    logic signed [X_W-1:0] r_g1;
    logic [IDX_W-1:0]      r_idx1;
    logic [FRAC_W-1:0]     r_frac1;
    logic                  r_lo1;
    logic                  r_hi1;

    // Stage 2 registers.
    t_op                       r_op2;
    logic signed [X_W-1:0]     r_x2;
    logic signed [X_W-1:0]     r_g2;
    t_samp                     r_base2;
    logic signed [IPROD_W-1:0] r_iprod2;

    // Stage 3 register is the outgoing beat.
    t_mid_beat r_beat3;

    logic signed [OFF_W-1:0]   n_off;
    logic                      n_lo;
    logic                      n_hi;
    logic [P_W-1:0]            n_pos;
    t_rom_entry                n_entry;
    t_samp                     n_base;
    logic signed [DELTA_W-1:0] n_delta;
    logic signed [IPROD_W-1:0] n_iprod;
    logic signed [NUM_W-1:0]   n_num;
    logic signed [NUM_W-1:0]   n_quo;
    t_samp                     n_sig;

    // A stage moves on when it is empty or the next one moves on.
    always_comb begin
        en[2] = !r_vld[2] || o_mid.ready;
        en[1] = !r_vld[1] || en[2];
        en[0] = !r_vld[0] || en[1];
    end

    assign i_in.ready = en[0];

    // Offset the input so the table span starts at zero and split it
    // into a segment index and a position inside the segment.
    always_comb begin
        n_off = {{(OFF_W - X_W){i_in.x_sample[X_W-1]}}, i_in.x_sample} + OFF_BIAS;
        n_lo  = n_off[OFF_W-1];
        n_hi  = !n_lo && (n_off >= OFF_LIM);
        n_pos = P_W'(n_off[FRAC_W-1:0]) * P_W'(SIGMOID_TABLE_ENTRIES);
    end

    // Table read and slope times position.
    always_comb begin
        n_entry = SIG_ROM[r_idx1];
        if (r_lo1) begin
            n_base  = SIG_ROM[0].base;
            n_delta = '0;
        end else if (r_hi1) begin
            n_base  = TAB_TOP;
            n_delta = '0;
        end else begin
            n_base  = n_entry.base;
            n_delta = n_entry.delta;
        end
        n_iprod = n_delta * $signed({1'b0, r_frac1});
    end

    // Round the interpolation step, truncating toward zero after the half bias.
    always_comb begin
        n_num = {r_iprod2[IPROD_W-1], r_iprod2} + $signed(INTERP_RND);
        if (n_num[NUM_W-1]) begin
            n_quo = -((-n_num) >>> FRAC_W);
        end else begin
            n_quo = n_num >>> FRAC_W;
        end
        n_sig = r_base2 + n_quo[SAMP_W-1:0];
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_in.valid;
            if (en[1]) r_vld[1] <= r_vld[0];
            if (en[2]) r_vld[2] <= r_vld[1];
        end
    end

    // Payload stages.
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_op1   <= i_in.op;
            r_x1    <= i_in.x_sample;
            r_g1    <= i_in.grad_in;
            r_idx1  <= n_pos[P_W-1:FRAC_W];
            r_frac1 <= n_pos[FRAC_W-1:0];
            r_lo1   <= n_lo;
            r_hi1   <= n_hi;
        end
        if (en[1]) begin
            r_op2    <= r_op1;
            r_x2     <= r_x1;
            r_g2     <= r_g1;
            r_base2  <= n_base;
            r_iprod2 <= n_iprod;
        end
        if (en[2]) begin
            r_beat3.op       <= r_op2;
            r_beat3.x_sample <= r_x2;
            r_beat3.grad_in  <= r_g2;
            r_beat3.sig      <= n_sig;
        end
    end

    assign o_mid.valid = r_vld[2];
    assign o_mid.beat  = r_beat3;

endmodule

`default_nettype wire

// ===== design/swa_core.sv =====
// Five-stage swish and swish-gradient arithmetic with rounding and saturation.
`default_nettype none

module swa_core (
    input  wire           i_clk,
    input  wire           i_rst_n,
    swa_mid_if.sink       i_mid,
    swa_out_if.source     o_out
);
    import swa_pkg::*;

    localparam int NSTG = 5;

    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] en;

    // Stage 4: forward product and s*(1-s).
    t_op                       r_op4;
    logic signed [X_W-1:0]     r_x4;
    logic signed [X_W-1:0]     r_g4;
    t_samp                     r_s4;
    logic signed [FPROD_W-1:0] r_fprod4;
    logic [Q_W-1:0]            r_q4;

    // Stage 5: x*s*(1-s) and rounded forward value.
    t_op                       r_op5;
    logic signed [X_W-1:0]     r_g5;
    t_samp                     r_s5;
    logic signed [XQ_W-1:0]    r_xq5;
    logic signed [FY_W-1:0]    r_fy5;

    // Stage 6: local derivative.
    t_op                       r_op6;
    logic signed [X_W-1:0]     r_g6;
    logic signed [DQ_W-1:0]    r_dq6;
    logic signed [FY_W-1:0]    r_fy6;

    // Stage 7: gradient product.
    t_op                       r_op7;
    logic signed [GP_W-1:0]    r_gp7;
    logic signed [FY_W-1:0]    r_fy7;

    // Stage 8: output register.
    logic signed [X_W-1:0]     r_y;
    logic                      r_sat;

    logic [SAMP_W-1:0]         n_omb;
    logic signed [FPROD_W-1:0] n_fprod;
    logic [Q_W-1:0]            n_q;
    logic [FPROD_W-1:0]        n_fsum;
    logic signed [XQ_W-1:0]    n_xq;
    logic [BIG_W-1:0]          n_big;
    logic [BIG_W-1:0]          n_bsum;
    logic signed [GP_W-1:0]    n_gp;
    logic [GP_W-1:0]           n_gsum;
    logic signed [BY_W-1:0]    n_res;
    logic signed [X_W-1:0]     n_y;
    logic                      n_sat;

    // A stage moves on when it is empty or the next one moves on.
    always_comb begin
        en[NSTG-1] = !r_vld[NSTG-1] || o_out.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign i_mid.ready = en[0];

    // Stage 4 inputs.
    always_comb begin
        n_omb   = Q16_ONE - i_mid.beat.sig;
        n_fprod = i_mid.beat.x_sample * $signed({1'b0, i_mid.beat.sig});
        n_q     = Q_W'(i_mid.beat.sig * n_omb);
    end

    // Stage 5 inputs.
    always_comb begin
        n_xq   = r_x4 * $signed({1'b0, r_q4});
        n_fsum = r_fprod4 + FWD_RND;
    end

    // Stage 6 inputs: s plus x*s*(1-s), back to Q16.
    always_comb begin
        n_big  = (BIG_W'(r_s5) << (FRAC_BITS + 16))
               + {{(BIG_W - XQ_W){r_xq5[XQ_W-1]}}, r_xq5};
        n_bsum = n_big + DQ_RND;
    end

    // Stage 7 inputs.
    always_comb begin
        n_gp = r_g6 * r_dq6;
    end

    // Stage 8 inputs: round, select the result and clip it to 16 bits.
    always_comb begin
        n_gsum = r_gp7 + GRAD_RND;
        if (r_op7 == OP_BWD) begin
            n_res = $signed(n_gsum[GP_W-1:16]);
        end else begin
            n_res = {{(BY_W - FY_W){r_fy7[FY_W-1]}}, r_fy7};
        end
        if (n_res > Y_MAX) begin
            n_y   = Y_MAX[X_W-1:0];
            n_sat = 1'b1;
        end else if (n_res < Y_MIN) begin
            n_y   = Y_MIN[X_W-1:0];
            n_sat = 1'b1;
        end else begin
            n_y   = n_res[X_W-1:0];
            n_sat = 1'b0;
        end
    end

    // Valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) r_vld[0] <= i_mid.valid;
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Payload stages.
    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r_op4    <= i_mid.beat.op;
            r_x4     <= i_mid.beat.x_sample;
            r_g4     <= i_mid.beat.grad_in;
            r_s4     <= i_mid.beat.sig;
            r_fprod4 <= n_fprod;
            r_q4     <= n_q;
        end
        if (en[1]) begin
            r_op5 <= r_op4;
            r_g5  <= r_g4;
            r_s5  <= r_s4;
            r_xq5 <= n_xq;
            r_fy5 <= $signed(n_fsum[FPROD_W-1:16]);
        end
        if (en[2]) begin
            r_op6 <= r_op5;
            r_g6  <= r_g5;
            r_dq6 <= $signed(n_bsum[BIG_W-1:FRAC_BITS+16]);
            r_fy6 <= r_fy5;
        end
        if (en[3]) begin
            r_op7 <= r_op6;
            r_gp7 <= n_gp;
            r_fy7 <= r_fy6;
        end
        if (en[4]) begin
            r_y   <= n_y;
            r_sat <= n_sat;
        end
    end

    assign o_out.valid     = r_vld[NSTG-1];
    assign o_out.y_value   = r_y;
    assign o_out.saturated = r_sat;

endmodule

`default_nettype wire

// ===== design/swa_checker.sv =====
// Port-level assertions for the swish unit, bound to the top level.
`default_nettype none

module swa_checker (
    input wire                        i_clk,
    input wire                        i_rst_n,
    input wire                        i_in_valid,
    input wire                        i_in_ready,
    input wire                        i_out_valid,
    input wire                        i_out_ready,
    input wire [swa_pkg::X_W-1:0]     i_y_value,
    input wire                        i_saturated
);
    import swa_pkg::*;

    localparam int CNT_W = $clog2(PIPE_DEPTH + 1) + 1;

    logic             in_beat;
    logic             out_beat;
    logic [CNT_W-1:0] r_cnt;

    assign in_beat  = i_in_valid && i_in_ready;
    assign out_beat = i_out_valid && i_out_ready;

    // Items taken in and not yet delivered.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (in_beat && !out_beat) begin
            r_cnt <= r_cnt + CNT_W'(1);
        end else if (out_beat && !in_beat) begin
            r_cnt <= r_cnt - CNT_W'(1);
        end
    end

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_y_value)
                                        && $stable(i_saturated))
        else $error("stalled result changed");

    // No result without an accepted item behind it.
    a_no_invent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_cnt != '0)
        else $error("result without an item");

    // The pipeline never holds more items than it has stages.
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(PIPE_DEPTH))
        else $error("more items in flight than stages");

    // A clipped result sits at a range limit.
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_saturated |-> i_y_value == X_W'(16'h7fff)
                                       || i_y_value == X_W'(16'h8000))
        else $error("saturation flag on an unclipped value");

endmodule

bind swish_activation_fwd_bwd swa_checker u_swa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_y_value   (o_out.y_value),
    .i_saturated (o_out.saturated)
);

`default_nettype wire

// ===== tb/swish_result_checker.sv =====
// Checker that predicts each swish result from the input beats and compares the output beats.
`default_nettype none

module swish_result_checker
    import swa_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    swa_in_if    i_in,
    swa_out_if   i_res,
    output int   o_fail_count,
    output int   o_pending
);

    localparam int N = SIGMOID_TABLE_ENTRIES;

    typedef struct packed {
        logic signed [X_W-1:0] y_value;
        logic                  saturated;
    } t_swish_result;

    // Sigmoid samples over [-8, 8], unsigned Q16, one more than the number of segments.
    longint        sig_samples [0:N];
    t_swish_result expected_results [$];
    int            mismatches = 0;

    // Rounded Q30 product.
    function automatic longint q30_product(longint a, longint b);
        return (a * b + (longint'(1) <<< 29)) >>> 30;
    endfunction

    // Divide by 2^sh, rounding half up.
    function automatic longint round_shift(longint v, int sh);
        return (v + (longint'(1) <<< (sh - 1))) >>> sh;
    endfunction

    // Sigmoid at sample point i; exp(-|x|) is a short series at |x|/256 squared eight times.
    function automatic longint sigmoid_point(int i);
        longint t;
        longint m;
        longint y;
        longint y2;
        longint y3;
        longint y4;
        longint e;
        longint den;
        t  = 16 * longint'(i) - 8 * longint'(N);
        m  = (t < 0) ? -t : t;
        y  = ((m <<< 22) + longint'(N / 2)) / longint'(N);
        y2 = q30_product(y, y);
        y3 = q30_product(y2, y);
        y4 = q30_product(y3, y);
        e  = (longint'(1) <<< 30) - y + y2 / 2 - y3 / 6 + y4 / 24;
        for (int k = 0; k < 8; k++) begin
            e = q30_product(e, e);
        end
        den = (longint'(1) <<< 30) + e;
        if (t >= 0) begin
            return ((longint'(1) <<< 46) + den / 2) / den;
        end
        return ((e <<< 16) + den / 2) / den;
    endfunction

    // Interpolated sigmoid of a Q4.12 input, clamped to the end samples.
    function automatic longint sigmoid_at(longint x);
        longint span;
        longint off;
        longint p;
        longint seg;
        longint frac;
        span = longint'(16) <<< FRAC_BITS;
        off  = x + (longint'(8) <<< FRAC_BITS);
        if (off < 0) begin
            return sig_samples[0];
        end
        p = off * N;
        if (p >= span * N) begin
            return sig_samples[N];
        end
        seg  = p / span;
        frac = p % span;
        return sig_samples[seg]
            + ((sig_samples[seg + 1] - sig_samples[seg]) * frac + span / 2) / span;
    endfunction

    // Swish value or input gradient, saturated to 16 bits.
    function automatic t_swish_result predict_swish(t_op op, logic signed [X_W-1:0] xs,
                                                    logic signed [X_W-1:0] gs);
        longint        x;
        longint        g;
        longint        s;
        longint        acc;
        longint        dq;
        longint        y;
        t_swish_result r;
        x = xs;
        g = gs;
        s = sigmoid_at(x);
        if (op == OP_FWD) begin
            y = round_shift(x * s, 16);
        end else begin
            acc = s * (longint'(1) <<< (FRAC_BITS + 16)) + x * s * (longint'(65536) - s);
            dq  = round_shift(acc, FRAC_BITS + 16);
            y   = round_shift(g * dq, 16);
        end
        r.saturated = 1'b0;
        if (y > 32767) begin
            y           = 32767;
            r.saturated = 1'b1;
        end
        if (y < -32768) begin
            y           = -32768;
            r.saturated = 1'b1;
        end
        r.y_value = y[X_W-1:0];
        return r;
    endfunction

    initial begin
        for (int i = 0; i <= N; i++) begin
            sig_samples[i] = sigmoid_point(i);
        end
    end

    // Check each result beat against the oldest expectation, then record new input beats.
    always @(posedge i_clk) begin
        t_swish_result want;
        if (i_rst_n) begin
            if (i_res.valid && i_res.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result y=%0d sat=%0b", $time,
                             i_res.y_value, i_res.saturated);
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    if (i_res.y_value !== want.y_value || i_res.saturated !== want.saturated)
                    begin
                        $display("%0t: result mismatch, expected y=%0d sat=%0b, got y=%0d sat=%0b",
                                 $time, want.y_value, want.saturated,
                                 i_res.y_value, i_res.saturated);
                        mismatches++;
                    end
                end
            end
            if (i_in.valid && i_in.ready) begin
                expected_results.push_back(predict_swish(i_in.op, i_in.x_sample, i_in.grad_in));
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= expected_results.size();
    end

endmodule

`default_nettype wire

// ===== tb/swish_activation_fwd_bwd_test.sv =====
// Top of the swish unit testbench: clock, reset, stimulus, output flow control and verdict.
`default_nettype none

module swish_activation_fwd_bwd_test;
    import swa_pkg::*;

    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int PHASE_ITEMS    = 390;

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_asked     = 0;
    int   hold_served    = 0;
    int   quiet_cycles   = 0;

    swa_in_if  in_ch ();
    swa_out_if out_ch ();

    swish_activation_fwd_bwd uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    swish_result_checker checker_inst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_res        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Output flow control: random stalls, plus one long hold-off when asked.
    initial begin
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_served) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_served++;
            end else begin
                out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Ends the run when no beat moves on either channel for too long.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL swish_activation_fwd_bwd");
            $finish;
        end
    end

    // Offers one beat after a random gap and returns at the edge where it is taken.
    task automatic send_beat(t_op op, logic signed [X_W-1:0] x, logic signed [X_W-1:0] g);
        int gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct && gap < 50) begin
            gap++;
        end
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.op       <= op;
        in_ch.x_sample <= x;
        in_ch.grad_in  <= g;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // Random beats: mostly uniform inputs, with segment edges, the steep region and
    // extreme gradients mixed in.
    task automatic send_random(int count);
        t_op                   op;
        logic signed [X_W-1:0] x;
        logic signed [X_W-1:0] g;
        int                    sel;
        for (int k = 0; k < count; k++) begin
            op  = t_op'($urandom_range(1));
            sel = $urandom_range(9);
            if (sel < 6) begin
                x = X_W'($urandom());
            end else if (sel < 8) begin
                x = X_W'($urandom_range(6 * 4096)) - X_W'(3 * 4096);
            end else begin
                x = {8'($urandom()), ($urandom_range(1) != 0) ? 8'hff : 8'h00};
            end
            if ($urandom_range(9) < 7) begin
                g = X_W'($urandom());
            end else begin
                case ($urandom_range(3))
                    0:       g = 16'sh7fff;
                    1:       g = 16'sh8000;
                    2:       g = '0;
                    default: g = '1;
                endcase
            end
            send_beat(op, x, g);
        end
    endtask

    initial begin
        i_rst_n        = 1'b0;
        in_ch.valid    = 1'b0;
        in_ch.op       = OP_FWD;
        in_ch.x_sample = '0;
        in_ch.grad_in  = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Forward: range ends, zero, unit steps, segment edges; grad must not matter.
        send_beat(OP_FWD, 16'sh8000, 16'sh7fff);
        send_beat(OP_FWD, 16'sh7fff, 16'sh8000);
        send_beat(OP_FWD, 16'sh0000, 16'sh0000);
        send_beat(OP_FWD, -16'sd1, 16'sh1234);
        send_beat(OP_FWD, 16'sd1, 16'sh0000);
        send_beat(OP_FWD, 16'sd256, 16'sh0000);
        send_beat(OP_FWD, 16'sd255, 16'sh0000);
        send_beat(OP_FWD, -16'sd256, 16'sh0000);
        send_beat(OP_FWD, 16'sd4096, 16'sh0000);
        send_beat(OP_FWD, -16'sd4096, 16'sh0000);
        send_beat(OP_FWD, 16'sd9830, 16'sh7fff);

        // Backward: extremes, the peak of the derivative (clips both ways), tiny values.
        send_beat(OP_BWD, 16'sh0000, 16'sh7fff);
        send_beat(OP_BWD, 16'sh8000, 16'sh8000);
        send_beat(OP_BWD, 16'sh8000, 16'sh7fff);
        send_beat(OP_BWD, 16'sh7fff, 16'sh7fff);
        send_beat(OP_BWD, 16'sh7fff, 16'sh8000);
        send_beat(OP_BWD, 16'sd9830, 16'sh7fff);
        send_beat(OP_BWD, 16'sd9830, 16'sh8000);
        send_beat(OP_BWD, -16'sd1, 16'sd1);
        send_beat(OP_BWD, 16'sd1, -16'sd1);
        send_beat(OP_BWD, 16'sh0000, 16'sh0000);
        send_beat(OP_BWD, -16'sd4096, 16'sd4096);

        // Streaming with no idling on either side.
        send_random(PHASE_ITEMS);

        send_idle_pct  = 60;
        recv_stall_pct = 0;
        send_random(PHASE_ITEMS);

        send_idle_pct  = 0;
        recv_stall_pct = 60;
        send_random(PHASE_ITEMS);

        send_idle_pct  = 35;
        recv_stall_pct = 35;
        send_random(PHASE_ITEMS);

        // Output held off for a long stretch while input keeps coming, to fill the pipe.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_asked <= hold_asked + 1;
        send_random(PHASE_ITEMS);

        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 4) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("PASS swish_activation_fwd_bwd");
        end else begin
            $display("FAIL swish_activation_fwd_bwd");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== swish_activation_fwd_bwd.f =====
design/swa_pkg.sv
design/swa_if.sv
design/swa_sigmoid.sv
design/swa_core.sv
design/swish_activation_fwd_bwd.sv
design/swa_checker.sv
tb/swish_result_checker.sv
tb/swish_activation_fwd_bwd_test.sv
